@@ src/assert_macros.svh @@
// assertion macros shared by the queue rtl
// checks compile only in simulation, synthesis sees empty bodies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_CHK(lbl, clk, rst_n, prop) \
    `ASSERT_PROP(lbl, clk, rst_n, prop, "queue assertion failed")
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_CHK(lbl, clk, rst_n, prop)
`endif
`endif

@@ src/deiq_pkg.sv @@
// types and codes of the double-ended indexed queue
// used by the controller, the datapath and the top level
`timescale 1ns / 1ps
`default_nettype none
package deiq_pkg;

    localparam int CMD_W    = 3;
    localparam int VAL_W    = 32;
    localparam int IDX_W    = 7;
    localparam int STAT_W   = 2;
    localparam int IN_TDW   = 48;
    localparam int OUT_TDW  = 48;

    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_RESIZE     = 3'd4;
    localparam logic [CMD_W-1:0] CMD_READ       = 3'd5;
    localparam logic [CMD_W-1:0] CMD_WRITE      = 3'd6;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_READ = 4'b0100,
        S_FILL = 4'b1000
    } t_state;

    typedef struct packed {
        logic load_in;
        logic exec;
        logic read_emit;
        logic fill;
    } t_ctl_cmd;

    typedef struct packed {
        logic out_free;
        logic read_hit;
        logic grow;
        logic fill_last;
    } t_dp_stat;

endpackage
`default_nettype wire

@@ src/deiq_ctrl.sv @@
// controller state machine of the queue
// sequences accept, execute, read and zero fill; uses deiq_pkg
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module deiq_ctrl
    import deiq_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_dp_stat i_stat,
    output t_ctl_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_stat.out_free) begin
                    o_cmd.exec = 1'b1;
                    if (i_stat.read_hit) begin
                        n_state = S_READ;
                    end else if (i_stat.grow) begin
                        n_state = S_FILL;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_READ: begin
                if (i_stat.out_free) begin
                    o_cmd.read_emit = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_FILL: begin
                o_cmd.fill = 1'b1;
                if (i_stat.fill_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `ASSERT_CHK(a_accept_to_exec, i_clk, i_rst_n, (i_in_valid && o_in_ready) |=> (r_state == S_EXEC))
    `ASSERT_CHK(a_state_onehot, i_clk, i_rst_n, $onehot(r_state))
    `ASSERT_CHK(a_fill_grows, i_clk, i_rst_n, (r_state == S_FILL) |-> i_stat.grow)

endmodule
`default_nettype wire

@@ src/deiq_datapath.sv @@
// datapath of the queue: circular store, head and count, result register
// driven by deiq_ctrl commands; uses deiq_pkg
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module deiq_datapath
    import deiq_pkg::*;
#(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_ctl_cmd           i_cmd,
    output t_dp_stat                o_stat,
    input  wire logic [IN_TDW-1:0]  i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [OUT_TDW-1:0]      o_out_data
);

    localparam int AW   = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > IDX_W) ? CW : IDX_W;

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];

    logic [CMD_W-1:0]      r_op;
    logic [DATA_WIDTH-1:0] r_val;
    logic [IDX_W-1:0]      r_idx;
    logic [AW-1:0]         r_head;
    logic [CW-1:0]         r_count;
    logic [DATA_WIDTH-1:0] r_q;
    logic                  r_out_valid;
    logic [OUT_TDW-1:0]    r_out_data;

    logic [AW-1:0]         n_head;
    logic [CW-1:0]         n_count;

    logic [VAL_W+63:0]          in_val_ext;
    logic [DATA_WIDTH+31:0]     rd_ext;
    logic [CMPW-1:0]            cnt_x;
    logic [CMPW-1:0]            idx_x;
    logic [CMPW-1:0]            cnt_inc_x;
    logic [CMPW-1:0]            depth_x;
    logic [AW-1:0]              slot_cnt;
    logic [AW-1:0]              slot_idx;
    logic [AW-1:0]              head_dec;
    logic [AW-1:0]              head_inc;
    logic                       is_full;
    logic                       is_empty;
    logic                       in_range;
    logic                       size_ok;
    logic                       grow;
    logic                       read_hit;
    logic                       out_free;
    logic                       load_out;
    logic [STAT_W-1:0]          res_status;
    logic [VAL_W-1:0]           res_data;
    logic                       wr_en;
    logic [AW-1:0]              wr_addr;
    logic [DATA_WIDTH-1:0]      wr_data;

    function automatic logic [AW-1:0] slot_add(input logic [AW-1:0] h, input logic [AW-1:0] p);
        logic [AW:0] s;
        s = {1'b0, h} + {1'b0, p};
        if (s >= (AW+1)'(DEPTH)) begin
            s = s - (AW+1)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    assign in_val_ext = {{64{i_in_data[CMD_W+VAL_W-1]}}, i_in_data[CMD_W +: VAL_W]};
    assign rd_ext     = {{32{r_q[DATA_WIDTH-1]}}, r_q};

    assign cnt_x     = CMPW'(r_count);
    assign idx_x     = CMPW'(r_idx);
    assign cnt_inc_x = cnt_x + CMPW'(1);
    assign depth_x   = CMPW'(DEPTH);

    assign slot_cnt = slot_add(r_head, cnt_x[AW-1:0]);
    assign slot_idx = slot_add(r_head, idx_x[AW-1:0]);
    assign head_dec = (r_head == '0) ? AW'(DEPTH - 1) : r_head - AW'(1);
    assign head_inc = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + AW'(1);

    assign is_full  = (cnt_x == depth_x);
    assign is_empty = (r_count == '0);
    assign in_range = (idx_x < cnt_x);
    assign size_ok  = (idx_x <= depth_x);
    assign grow     = (r_op == CMD_RESIZE) && size_ok && (idx_x > cnt_x);
    assign read_hit = (r_op == CMD_READ) && in_range;
    assign out_free = !r_out_valid || i_out_ready;

    assign o_stat.out_free  = out_free;
    assign o_stat.read_hit  = read_hit;
    assign o_stat.grow      = grow;
    assign o_stat.fill_last = (cnt_inc_x == idx_x);

    always_comb begin
        res_status = ST_OK;
        n_count    = r_count;
        n_head     = r_head;
        wr_en      = 1'b0;
        wr_addr    = slot_cnt;
        wr_data    = r_val;
        if (i_cmd.exec) begin
            case (r_op)
                CMD_PUSH_BACK: begin
                    if (is_full) begin
                        res_status = ST_FULL;
                    end else begin
                        wr_en   = 1'b1;
                        n_count = r_count + CW'(1);
                    end
                end
                CMD_PUSH_FRONT: begin
                    if (is_full) begin
                        res_status = ST_FULL;
                    end else begin
                        wr_en   = 1'b1;
                        wr_addr = head_dec;
                        n_head  = head_dec;
                        n_count = r_count + CW'(1);
                    end
                end
                CMD_POP_FRONT: begin
                    if (is_empty) begin
                        res_status = ST_EMPTY;
                    end else begin
                        n_head  = head_inc;
                        n_count = r_count - CW'(1);
                    end
                end
                CMD_POP_BACK: begin
                    if (is_empty) begin
                        res_status = ST_EMPTY;
                    end else begin
                        n_count = r_count - CW'(1);
                    end
                end
                CMD_RESIZE: begin
                    if (!size_ok) begin
                        res_status = ST_FULL;
                    end else if (!grow) begin
                        n_count = idx_x[CW-1:0];
                    end
                end
                CMD_READ: begin
                    if (!in_range) begin
                        res_status = ST_RANGE;
                    end
                end
                CMD_WRITE: begin
                    if (!in_range) begin
                        res_status = ST_RANGE;
                    end else begin
                        wr_en   = 1'b1;
                        wr_addr = slot_idx;
                    end
                end
                default: begin
                    res_status = ST_OK;
                end
            endcase
        end else if (i_cmd.fill) begin
            wr_en   = 1'b1;
            wr_data = '0;
            n_count = r_count + CW'(1);
        end
    end

    assign load_out = (i_cmd.exec && !read_hit && !grow) || i_cmd.read_emit
                   || (i_cmd.fill && o_stat.fill_last);
    assign res_data = i_cmd.read_emit ? rd_ext[VAL_W-1:0] : '0;

    // store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_q <= r_mem[slot_idx];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op  <= i_in_data[CMD_W-1:0];
            r_val <= in_val_ext[DATA_WIDTH-1:0];
            r_idx <= i_in_data[CMD_W+VAL_W +: IDX_W];
        end
        if (load_out) begin
            r_out_data <= {(OUT_TDW - VAL_W - STAT_W - IDX_W)'(0),
                           CMPW'(n_count) >> 0 == '0 ? IDX_W'(0) : IDX_W'(CMPW'(n_count)),
                           res_status, res_data};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    `ASSERT_CHK(a_count_range, i_clk, i_rst_n, (cnt_x <= depth_x))
    `ASSERT_CHK(a_head_range, i_clk, i_rst_n, ((AW+1)'(r_head) < (AW+1)'(DEPTH)))
    `ASSERT_CHK(a_load_free, i_clk, i_rst_n, load_out |-> out_free)
    `ASSERT_CHK(a_fill_below, i_clk, i_rst_n, i_cmd.fill |-> (cnt_x < idx_x))

endmodule
`default_nettype wire

@@ src/double_ended_indexed_queue_unit.sv @@
// top level of the double-ended indexed queue
// joins deiq_ctrl and deiq_datapath; uses deiq_pkg
`timescale 1ns / 1ps
`default_nettype none
// Double-ended indexed queue of up to DEPTH elements in a circular store. Each input
// word carries one command (push back or front, pop front or back, resize, indexed
// read, indexed write) and gives exactly one result word with read data, status and
// the length after the command. Push, pop, write and resize without growth pass through
// accept, then execute; an in-range read adds a read state because the store has a
// registered read port; a resize that grows by n elements adds a zero fill, which writes
// one entry per cycle through the single write port. A result waits in an output
// register, so the next word is accepted while it is still unclaimed.
module double_ended_indexed_queue_unit
    import deiq_pkg::*;
#(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_s_axis_tvalid,
    output logic                    o_s_axis_tready,
    input  wire logic [IN_TDW-1:0]  i_s_axis_tdata,  // cmd, value, index_or_size
    output logic                    o_m_axis_tvalid,
    input  wire logic               i_m_axis_tready,
    output logic [OUT_TDW-1:0]      o_m_axis_tdata   // read_data, status, length
);

    t_ctl_cmd ctl_cmd;
    t_dp_stat dp_stat;

    deiq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (dp_stat),
        .o_cmd      (ctl_cmd)
    );

    deiq_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (ctl_cmd),
        .o_stat      (dp_stat),
        .i_in_data   (i_s_axis_tdata),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out_data  (o_m_axis_tdata)
    );

endmodule
`default_nettype wire

@@ sim/tb_top.sv @@
// self-checking bench for double_ended_indexed_queue_unit
// directed table with set results, random words checked by a shadow deque
// depends on deiq_pkg and the rtl under src only
`timescale 1ns / 1ps
module tb_top;
    import deiq_pkg::*;

    localparam int DEPTH = 64;
    localparam int RANDOM_WORDS = 650;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 80;
    localparam int IDLE_PCT = 38;
    localparam int PENDING_DEPTH = 64;
    localparam int DIRECTED_COUNT = 25;
    localparam logic [CMD_W-1:0] CMD_NOP = 3'd7;

    typedef struct packed {
        logic [VAL_W-1:0]  read_data;
        logic [STAT_W-1:0] status;
        logic [IDX_W-1:0]  length;
    } t_deque_result;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [VAL_W-1:0] val;
        logic [IDX_W-1:0] idx;
        logic             typed;
        t_deque_result    res;
    } t_stim_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_s_axis_tvalid = 1'b0;
    logic [IN_TDW-1:0] i_s_axis_tdata = '0;
    logic i_m_axis_tready = 1'b0;
    logic o_s_axis_tready;
    logic o_m_axis_tvalid;
    logic [OUT_TDW-1:0] o_m_axis_tdata;

    logic [VAL_W-1:0] shadow_slots [DEPTH];
    logic [5:0]       shadow_head = '0;
    logic [IDX_W-1:0] shadow_len = '0;

    t_deque_result pending_results [PENDING_DEPTH];
    int pending_wr = 0;
    int pending_rd = 0;
    int error_count = 0;
    int stall_cycles = 0;
    bit idle_enable = 1'b1;

    localparam t_stim_row DIRECTED_ROWS [DIRECTED_COUNT] = '{
        '{CMD_POP_FRONT,  32'd0,        7'd0,   1'b1, '{32'd0,        ST_EMPTY, 7'd0}},
        '{CMD_POP_BACK,   32'd0,        7'd0,   1'b1, '{32'd0,        ST_EMPTY, 7'd0}},
        '{CMD_READ,       32'd0,        7'd0,   1'b1, '{32'd0,        ST_RANGE, 7'd0}},
        '{CMD_WRITE,      32'd5,        7'd0,   1'b1, '{32'd0,        ST_RANGE, 7'd0}},
        '{CMD_RESIZE,     32'd0,        7'd65,  1'b1, '{32'd0,        ST_FULL,  7'd0}},
        '{CMD_RESIZE,     32'hffffffff, 7'd127, 1'b1, '{32'd0,        ST_FULL,  7'd0}},
        '{CMD_NOP,        32'h12345678, 7'd3,   1'b1, '{32'd0,        ST_OK,    7'd0}},
        '{CMD_PUSH_BACK,  32'h7fffffff, 7'd0,   1'b1, '{32'd0,        ST_OK,    7'd1}},
        '{CMD_PUSH_FRONT, 32'h80000000, 7'd0,   1'b1, '{32'd0,        ST_OK,    7'd2}},
        '{CMD_READ,       32'd0,        7'd0,   1'b1, '{32'h80000000, ST_OK,    7'd2}},
        '{CMD_READ,       32'd0,        7'd1,   1'b1, '{32'h7fffffff, ST_OK,    7'd2}},
        '{CMD_READ,       32'd0,        7'd2,   1'b1, '{32'd0,        ST_RANGE, 7'd2}},
        '{CMD_WRITE,      32'hffffffff, 7'd1,   1'b1, '{32'd0,        ST_OK,    7'd2}},
        '{CMD_READ,       32'd0,        7'd1,   1'b1, '{32'hffffffff, ST_OK,    7'd2}},
        '{CMD_RESIZE,     32'd0,        7'd2,   1'b1, '{32'd0,        ST_OK,    7'd2}},
        '{CMD_RESIZE,     32'd0,        7'd64,  1'b1, '{32'd0,        ST_OK,    7'd64}},
        '{CMD_PUSH_BACK,  32'h11111111, 7'd0,   1'b1, '{32'd0,        ST_FULL,  7'd64}},
        '{CMD_PUSH_FRONT, 32'h22222222, 7'd0,   1'b1, '{32'd0,        ST_FULL,  7'd64}},
        '{CMD_READ,       32'd0,        7'd63,  1'b1, '{32'd0,        ST_OK,    7'd64}},
        '{CMD_READ,       32'd0,        7'd64,  1'b1, '{32'd0,        ST_RANGE, 7'd64}},
        '{CMD_WRITE,      32'h5a5a5a5a, 7'd63,  1'b0, '0},
        '{CMD_READ,       32'd0,        7'd63,  1'b0, '0},
        '{CMD_RESIZE,     32'd0,        7'd1,   1'b1, '{32'd0,        ST_OK,    7'd1}},
        '{CMD_POP_BACK,   32'd0,        7'd0,   1'b1, '{32'd0,        ST_OK,    7'd0}},
        '{CMD_POP_FRONT,  32'd0,        7'd0,   1'b1, '{32'd0,        ST_EMPTY, 7'd0}}
    };

    double_ended_indexed_queue_unit #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (VAL_W)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),  // cmd, value, index_or_size
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)   // read_data, status, length
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic t_deque_result deque_step(input logic [CMD_W-1:0] cmd,
                                                 input logic [VAL_W-1:0] val,
                                                 input logic [IDX_W-1:0] idx);
        t_deque_result r;
        logic [5:0] slot;
        r = '0;
        r.status = ST_OK;
        case (cmd)
            CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
                if (shadow_len >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    if (cmd == CMD_PUSH_FRONT) begin
                        shadow_head = shadow_head - 6'd1;
                        slot = shadow_head;
                    end else begin
                        slot = shadow_head + shadow_len[5:0];
                    end
                    shadow_slots[slot] = val;
                    shadow_len = shadow_len + 7'd1;
                end
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
                if (shadow_len == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    if (cmd == CMD_POP_FRONT) shadow_head = shadow_head + 6'd1;
                    shadow_len = shadow_len - 7'd1;
                end
            end
            CMD_RESIZE: begin
                if (idx > DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    // growth zero-fills the new tail positions
                    while (shadow_len < idx) begin
                        slot = shadow_head + shadow_len[5:0];
                        shadow_slots[slot] = '0;
                        shadow_len = shadow_len + 7'd1;
                    end
                    shadow_len = idx;
                end
            end
            CMD_READ, CMD_WRITE: begin
                slot = shadow_head + idx[5:0];
                if (idx >= shadow_len) r.status = ST_RANGE;
                else if (cmd == CMD_READ) r.read_data = shadow_slots[slot];
                else shadow_slots[slot] = val;
            end
            default: begin
            end
        endcase
        r.length = shadow_len;
        return r;
    endfunction

    task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [VAL_W-1:0] val,
                             input logic [IDX_W-1:0] idx, input logic typed,
                             input t_deque_result typed_res);
        t_deque_result predicted;
        while (idle_enable && $urandom_range(99) < IDLE_PCT) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {{(IN_TDW - CMD_W - VAL_W - IDX_W){1'b0}}, idx, val, cmd};
        do @(posedge i_clk); while (!o_s_axis_tready);
        predicted = deque_step(cmd, val, idx);
        pending_results[pending_wr % PENDING_DEPTH] = typed ? typed_res : predicted;
        pending_wr = pending_wr + 1;
    endtask

    task automatic pick_random_word(input bit filling, output logic [CMD_W-1:0] cmd,
                                    output logic [VAL_W-1:0] val,
                                    output logic [IDX_W-1:0] idx);
        int roll;
        int target;
        roll = $urandom_range(99);
        val = $urandom;
        idx = IDX_W'($urandom_range(127));
        if (roll < (filling ? 30 : 8)) cmd = CMD_PUSH_BACK;
        else if (roll < (filling ? 55 : 16)) cmd = CMD_PUSH_FRONT;
        else if (roll < (filling ? 62 : 38)) cmd = CMD_POP_FRONT;
        else if (roll < (filling ? 69 : 60)) cmd = CMD_POP_BACK;
        else if (roll < 82) cmd = CMD_READ;
        else if (roll < 92) cmd = CMD_WRITE;
        else if (roll < 99) cmd = CMD_RESIZE;
        else cmd = CMD_NOP;
        if ((cmd == CMD_READ || cmd == CMD_WRITE) && shadow_len != 0
                && $urandom_range(9) != 0) begin
            idx = IDX_W'($urandom_range(int'(shadow_len) - 1));
        end
        if (cmd == CMD_RESIZE) begin
            roll = $urandom_range(19);
            if (roll == 0) begin
                idx = 7'd64;
            end else if (roll > 1) begin
                // keep most resizes small so the zero fill stays short
                if (filling) target = int'(shadow_len) + $urandom_range(6);
                else target = $urandom_range(int'(shadow_len));
                idx = (target > DEPTH) ? 7'd64 : target[IDX_W-1:0];
            end
        end
    endtask

    always @(posedge i_clk) begin
        i_m_axis_tready <= !idle_enable || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    always @(posedge i_clk) begin : check_results
        t_deque_result got;
        t_deque_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.read_data = o_m_axis_tdata[31:0];
            got.status    = o_m_axis_tdata[33:32];
            got.length    = o_m_axis_tdata[40:34];
            if (pending_wr == pending_rd) begin
                if (error_count < 10)
                    $display("unexpected result word: data %h status %0d length %0d",
                             got.read_data, got.status, got.length);
                error_count = error_count + 1;
            end else begin
                want = pending_results[pending_rd % PENDING_DEPTH];
                pending_rd = pending_rd + 1;
                if (got.read_data !== want.read_data || got.status !== want.status
                        || got.length !== want.length) begin
                    if (error_count < 10)
                        $display("mismatch: data %h/%h status %0d/%0d length %0d/%0d",
                                 want.read_data, got.read_data, want.status, got.status,
                                 want.length, got.length);
                    error_count = error_count + 1;
                end
            end
        end
    end

    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        logic [CMD_W-1:0] cmd;
        logic [VAL_W-1:0] val;
        logic [IDX_W-1:0] idx;
        bit filling;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int n = 0; n < DIRECTED_COUNT; n++) begin
            send_word(DIRECTED_ROWS[n].cmd, DIRECTED_ROWS[n].val, DIRECTED_ROWS[n].idx,
                      DIRECTED_ROWS[n].typed, DIRECTED_ROWS[n].res);
        end
        filling = 1'b1;
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n % 90 == 0) filling = !filling;
            idle_enable = !(n >= 250 && n < 400);
            // hold off the sender until every result word is back
            if (n % 160 == 80) begin
                i_s_axis_tvalid <= 1'b0;
                do @(posedge i_clk); while (pending_wr != pending_rd);
            end
            pick_random_word(filling, cmd, val, idx);
            send_word(cmd, val, idx, 1'b0, '0);
        end
        i_s_axis_tvalid <= 1'b0;
        idle_enable = 1'b1;
        do @(posedge i_clk); while (pending_wr != pending_rd);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && pending_wr == pending_rd) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+src
src/deiq_pkg.sv
src/deiq_ctrl.sv
src/deiq_datapath.sv
src/double_ended_indexed_queue_unit.sv
sim/tb_top.sv
